[rtl/core/fkdc_pkg.sv]
// ----------------------------------------------------------------------------
// fkdc_pkg
// Shared types, widths and action codes for the key descriptor cache.
// ----------------------------------------------------------------------------
package fkdc_pkg;

   localparam int unsigned CACHE_ENTRIES_DEFAULT = 8;
   localparam int unsigned MAX_COLUMNS           = 64;

   localparam int unsigned ACTION_W = 2;
   localparam int unsigned KEY_W    = 32;
   localparam int unsigned COUNT_W  = 7;
   localparam int unsigned HANDLE_W = 32;

   // saturation limit, compared one bit wider than the count field
   localparam logic [COUNT_W:0]   MAX_COLUMNS_CMP = (COUNT_W + 1)'(MAX_COLUMNS);
   localparam logic [COUNT_W-1:0] MAX_COLUMNS_SAT = COUNT_W'(MAX_COLUMNS);

   typedef logic [ACTION_W-1:0] action_type;

   localparam action_type ACT_LOOKUP = 2'd0;
   localparam action_type ACT_FILL   = 2'd1;
   localparam action_type ACT_INVAL  = 2'd2;
   localparam action_type ACT_CLEAR  = 2'd3;

   typedef struct packed {
      logic                valid;
      action_type          action;
      logic [KEY_W-1:0]    key;
      logic [COUNT_W-1:0]  count;
      logic [HANDLE_W-1:0] handle;
   } cmd_type;

   typedef struct packed {
      logic                hit;
      logic [COUNT_W-1:0]  count;
      logic [HANDLE_W-1:0] handle;
   } look_type;

endpackage

[rtl/core/fkdc_entries.sv]
// ----------------------------------------------------------------------------
// fkdc_entries
// Entry array: parallel key compare with lowest-index priority, FIFO fill by
// shifting down, key invalidate and clear.
// ----------------------------------------------------------------------------
module fkdc_entries
   import fkdc_pkg::*;
#(
   parameter int unsigned Entries = CACHE_ENTRIES_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   output look_type look
);

   logic [KEY_W-1:0]    key_ff    [Entries];
   logic [KEY_W-1:0]    key_in    [Entries];
   logic [COUNT_W-1:0]  count_ff  [Entries];
   logic [COUNT_W-1:0]  count_in  [Entries];
   logic [HANDLE_W-1:0] handle_ff [Entries];
   logic [HANDLE_W-1:0] handle_in [Entries];
   logic [Entries-1:0]  live;
   logic [COUNT_W-1:0]  fill_count;

   always_comb begin
      for (int i = 0; i < int'(Entries); i++) begin
         live[i] = (count_ff[i] != '0);
      end
   end

   // lowest index wins: scan from the top so lower entries override
   always_comb begin
      look = '0;
      if (cmd.action == ACT_LOOKUP) begin
         for (int i = int'(Entries) - 1; i >= 0; i--) begin
            if (live[i] && (key_ff[i] == cmd.key)) begin
               look.hit    = 1'b1;
               look.count  = count_ff[i];
               look.handle = handle_ff[i];
            end
         end
      end
   end

   assign fill_count = ({1'b0, cmd.count} > MAX_COLUMNS_CMP) ? MAX_COLUMNS_SAT : cmd.count;

   always_comb begin
      key_in    = key_ff;
      count_in  = count_ff;
      handle_in = handle_ff;
      if (cmd.valid) begin
         unique case (cmd.action)
            ACT_LOOKUP: begin
            end
            ACT_FILL: begin
               if (cmd.count != '0) begin
                  for (int i = 0; i < int'(Entries) - 1; i++) begin
                     key_in[i]    = key_ff[i+1];
                     count_in[i]  = count_ff[i+1];
                     handle_in[i] = handle_ff[i+1];
                  end
                  key_in[Entries-1]    = cmd.key;
                  count_in[Entries-1]  = fill_count;
                  handle_in[Entries-1] = cmd.handle;
               end
            end
            ACT_INVAL: begin
               for (int i = 0; i < int'(Entries); i++) begin
                  if (key_ff[i] == cmd.key) begin
                     key_in[i]   = '0;
                     count_in[i] = '0;
                  end
               end
            end
            ACT_CLEAR: begin
               for (int i = 0; i < int'(Entries); i++) begin
                  key_in[i]   = '0;
                  count_in[i] = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < int'(Entries); i++) begin
            key_ff[i]   <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         key_ff   <= key_in;
         count_ff <= count_in;
      end
   end

   // handles are only visible behind a nonzero count
   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
   end

`ifndef ASSERT_OFF
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.valid && (cmd.action == ACT_CLEAR)) |=> (live == '0))
      else $error("entries still live after clear");

   a_fill_top: assert property (@(posedge clock) disable iff (reset)
      (cmd.valid && (cmd.action == ACT_FILL) && (cmd.count != '0))
      |=> (live[Entries-1] && (key_ff[Entries-1] == $past(cmd.key))))
      else $error("fill did not land in top entry");

   a_hit_live: assert property (@(posedge clock) disable iff (reset)
      look.hit |-> ((look.count != '0) && (cmd.action == ACT_LOOKUP)))
      else $error("hit reported on dead entry or non-lookup");
`endif

endmodule

[rtl/core/fifo_key_descriptor_cache.sv]
// ----------------------------------------------------------------------------
// fifo_key_descriptor_cache
// Small fully associative table-key cache with FIFO replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel takes one word per cycle while req_ready is high: action
//   (lookup, fill, invalidate, clear), table key, fill count and fill handle.
//   rsp_* channel returns exactly one word per request: hit, found count and
//   found handle (all zero for anything but a lookup hit).
//   An accepted request passes the input register, then the result register,
//   where rsp_valid rises.
//   Throughput: 1 word per cycle while rsp_ready is high; all entry keys are
//   compared in parallel and the fill shift completes in the same cycle.
//   Each request updates the entries as it moves to the result register, so
//   the next request sees its effect.
//   Reset: all keys and counts cleared, both stages empty.
//   Stall: with rsp_ready low the result holds, one more request waits in
//   the input register, and req_ready then drops until the result is taken.
// ----------------------------------------------------------------------------
module fifo_key_descriptor_cache
   import fkdc_pkg::*;
#(
   parameter int unsigned CACHE_ENTRIES = CACHE_ENTRIES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [KEY_W-1:0]    req_table_key,
   input  logic [COUNT_W-1:0]  req_fill_count,
   input  logic [HANDLE_W-1:0] req_fill_handle,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_hit,
   output logic [COUNT_W-1:0]  rsp_found_count,
   output logic [HANDLE_W-1:0] rsp_found_handle
);

   logic                s1_valid_ff, s1_valid_in;
   action_type          s1_action_ff;
   logic [KEY_W-1:0]    s1_key_ff;
   logic [COUNT_W-1:0]  s1_count_ff;
   logic [HANDLE_W-1:0] s1_handle_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;

   logic     advance;
   logic     req_take;
   cmd_type  cmd;
   look_type look;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign cmd.valid  = s1_valid_ff && advance;
   assign cmd.action = s1_action_ff;
   assign cmd.key    = s1_key_ff;
   assign cmd.count  = s1_count_ff;
   assign cmd.handle = s1_handle_ff;

   fkdc_entries #(
      .Entries (CACHE_ENTRIES)
   ) u_entries (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .look  (look)
   );

   assign s1_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff <= req_action;
         s1_key_ff    <= req_table_key;
         s1_count_ff  <= req_fill_count;
         s1_handle_ff <= req_fill_handle;
      end
      if (cmd.valid) begin
         rsp_hit_ff    <= look.hit;
         rsp_count_ff  <= look.count;
         rsp_handle_ff <= look.handle;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_found_count  = rsp_count_ff;
   assign rsp_found_handle = rsp_handle_ff;

`ifndef ASSERT_OFF
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> ((rsp_count_ff == '0) && (rsp_handle_ff == '0)))
      else $error("miss word carries nonzero payload");

   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff)
      |-> ((rsp_count_ff != '0) && ({1'b0, rsp_count_ff} <= MAX_COLUMNS_CMP)))
      else $error("hit count out of range");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_key_ff)))
      else $error("input stage lost a waiting word");
`endif

endmodule
